>>> hw/rtl/global_fp_response_time_analysis_top_assert.svh
// assertion macros of the checker file
`ifndef GLOBAL_FP_RESPONSE_TIME_ANALYSIS_TOP_ASSERT_SVH
`define GLOBAL_FP_RESPONSE_TIME_ANALYSIS_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GFRTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gfrta assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define GFRTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gfrta assertion failed");

`endif

>>> hw/rtl/gfrta_pkg.sv
// types and constants of the global fixed-priority response time analysis block
package gfrta_pkg;

    typedef struct packed {
        logic [31:0] exec_time;
        logic [31:0] task_period;
        logic [31:0] task_deadline;
        logic [32:0] prior_bound;
        logic        first_of_set;
    } t_in;

    typedef struct packed {
        logic [4:0]  task_index;
        logic [32:0] resp_time;
        logic [32:0] new_bound;
        logic [1:0]  status;
        logic        set_schedulable;
    } t_out;

    // result status codes
    localparam logic [1:0] ST_FIT     = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_NOTEXAM = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // pad added to the deadline when the iteration does not converge
    localparam logic [32:0] MISS_PAD = 33'd100;

    // divider step counts
    localparam logic [6:0] DIV_STEPS_32 = 7'd32;
    localparam logic [6:0] DIV_STEPS_64 = 7'd64;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic decide;
        logic test;
        logic rd;
        logic pstart;
        logic ceil;
        logic mul;
        logic acc;
        logic qstart;
        logic eval;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic miss_seen;
        logic full;
        logic r_ge_dl;
        logic j_end;
        logic div_busy;
        logic converged;
    } t_sts;

endpackage

>>> hw/rtl/global_fp_response_time_analysis_top.sv
// Global fixed-priority response time analysis. Tasks come in one transaction each, highest
// priority first; first_of_set empties the task table. Each task gives exactly one result
// transaction. A task that is not examined or finds the table full goes straight to its result.
// An analysed task runs window iterations until the window converges or reaches its deadline.
// Each iteration tests the window against the deadline, then per stored higher-priority task
// runs a 32-step ceil division by its period plus read, multiply and accumulate, then the
// 64-step division of the workload sum by the processor count and the convergence check.
// One shared radix-2 divider serves both divisions. The next task is taken once the current
// one has been handed to the output register; a result still stalled there holds back
// only the hand-over of the following task, which waits until that result is taken.
module global_fp_response_time_analysis_top
    import gfrta_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_in,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    gfrta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gfrta_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

>>> hw/rtl/gfrta_div.sv
// radix-2 restoring divider, 64-bit dividend, 32-bit divisor, one bit a cycle
module gfrta_div
    import gfrta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic [6:0]  i_steps,
    output logic        o_busy,
    output logic [63:0] o_quotient,
    output logic [31:0] o_remainder
);

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dsr;
    logic [32:0] n_shift;
    logic        n_ge;
    logic [32:0] n_diff;

    // one restoring step
    always_comb begin
        n_shift = {r_rem, r_dvd[63]};
        n_ge    = n_shift >= {1'b0, r_dsr};
        n_diff  = n_shift - {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operands, quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], n_ge};
            r_rem <= n_ge ? n_diff[31:0] : n_shift[31:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/gfrta_ctrl.sv
// controller state machine of the response time analysis
module gfrta_ctrl
    import gfrta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECIDE = 13'b0000000000010,
        S_TEST   = 13'b0000000000100,
        S_RD     = 13'b0000000001000,
        S_PSTART = 13'b0000000010000,
        S_PDIV   = 13'b0000000100000,
        S_CEIL   = 13'b0000001000000,
        S_MUL    = 13'b0000010000000,
        S_ACC    = 13'b0000100000000,
        S_QSTART = 13'b0001000000000,
        S_QDIV   = 13'b0010000000000,
        S_EVAL   = 13'b0100000000000,
        S_FINISH = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = (i_sts.miss_seen || i_sts.full) ? S_FINISH : S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state = i_sts.r_ge_dl ? S_FINISH : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = i_sts.j_end ? S_QSTART : S_PSTART;
            end
            S_PSTART: begin
                o_cmd.pstart = 1'b1;
                n_state = S_PDIV;
            end
            S_PDIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_CEIL;
                end
            end
            S_CEIL: begin
                o_cmd.ceil = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_RD;
            end
            S_QSTART: begin
                o_cmd.qstart = 1'b1;
                n_state = S_QDIV;
            end
            S_QDIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_sts.converged ? S_FINISH : S_TEST;
            end
            S_FINISH: begin
                if (!(r_out_valid && i_stall)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output transaction valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> hw/rtl/gfrta_dp.sv
// datapath: task table, window iteration, workload sum and result register
module gfrta_dp
    import gfrta_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  t_in        i_in,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output t_out       o_out
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TASKS);

    // task table, exec time in the upper half and period in the lower half
    logic [63:0] mem [MAX_TASKS];

    logic [6:0]    r_procs;
    t_in           r_in;
    logic [CW-1:0] r_count;
    logic          r_miss;
    logic [63:0]   r_r;
    logic [63:0]   r_sum;
    logic [CW-1:0] r_j;
    logic [63:0]   r_rd;
    logic [31:0]   r_n;
    logic [63:0]   r_prod;
    logic [1:0]    r_stat;
    logic [32:0]   r_resp;
    logic [4:0]    r_idx;
    t_out          r_out;

    logic          div_start;
    logic [63:0]   div_dvd;
    logic [31:0]   div_dsr;
    logic [6:0]    div_steps;
    logic          div_busy;
    logic [63:0]   div_q;
    logic [31:0]   div_rem;

    logic          full;
    logic [31:0]   per;
    logic [63:0]   n_add;
    logic [64:0]   n_acc;
    logic [64:0]   n_dem65;
    logic [63:0]   n_dem;
    logic [32:0]   n_bound;
    logic          n_miss;

    assign full = (r_count >= MAX_C);
    assign per  = (r_rd[31:0] == 32'd0) ? 32'd1 : r_rd[31:0];

    // divider operand selection
    always_comb begin
        div_start = i_cmd.pstart || i_cmd.qstart;
        if (i_cmd.qstart) begin
            div_dvd   = r_sum;
            div_dsr   = {25'd0, (r_procs == 7'd0) ? 7'd1 : r_procs};
            div_steps = DIV_STEPS_64;
        end else begin
            div_dvd   = {r_r[31:0], 32'd0};
            div_dsr   = per;
            div_steps = DIV_STEPS_32;
        end
    end

    gfrta_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dsr),
        .i_steps     (div_steps),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_rem)
    );

    // saturating sums and final bound
    always_comb begin
        n_add   = r_prod + {32'd0, r_rd[63:32]};
        n_acc   = {1'b0, r_sum} + {1'b0, n_add};
        n_dem65 = {1'b0, div_q} + {33'd0, r_in.exec_time};
        n_dem   = n_dem65[64] ? '1 : n_dem65[63:0];
        n_bound = (r_stat == ST_FIT && r_resp > r_in.prior_bound) ? r_resp
                                                                  : r_in.prior_bound;
        n_miss  = r_miss || (r_stat == ST_MISS);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_procs <= 7'd1;
        end else if (i_cfg_we) begin
            r_procs <= i_cfg_data;
        end
    end

    // table fill and miss flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_miss  <= 1'b0;
        end else if (i_cmd.load && i_in.first_of_set) begin
            r_count <= '0;
            r_miss  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_miss <= n_miss;
            if (r_stat != ST_FULL && !full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_stat != ST_FULL && !full) begin
            mem[r_count[AW-1:0]] <= {r_in.exec_time, r_in.task_period};
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_j[AW-1:0]];
        end
    end

    // iteration datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.decide) begin
            r_idx <= 5'(r_count);
            r_r   <= {32'd0, r_in.exec_time};
            r_resp <= '0;
            if (r_miss) begin
                r_stat <= ST_NOTEXAM;
            end else if (full) begin
                r_stat <= ST_FULL;
            end else begin
                r_stat <= ST_FIT;
            end
        end
        if (i_cmd.test) begin
            r_sum <= '0;
            r_j   <= '0;
            if (r_r >= {32'd0, r_in.task_deadline}) begin
                r_stat <= ST_MISS;
                r_resp <= {1'b0, r_in.task_deadline} + MISS_PAD;
            end
        end
        if (i_cmd.ceil) begin
            r_n <= div_q[31:0] + {31'd0, (div_rem != 32'd0)};
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_rd[63:32]) * 64'(r_n);
        end
        if (i_cmd.acc) begin
            r_sum <= n_acc[64] ? '1 : n_acc[63:0];
            r_j   <= r_j + CW'(1);
        end
        if (i_cmd.eval) begin
            if (n_dem == r_r) begin
                r_stat <= ST_FIT;
                r_resp <= r_r[32:0];
            end else begin
                r_r <= n_dem;
            end
        end
        if (i_cmd.finish) begin
            r_out.task_index      <= r_idx;
            r_out.resp_time       <= r_resp;
            r_out.new_bound       <= n_bound;
            r_out.status          <= r_stat;
            r_out.set_schedulable <= !n_miss;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.miss_seen = r_miss;
        o_sts.full      = full;
        o_sts.r_ge_dl   = (r_r >= {32'd0, r_in.task_deadline});
        o_sts.j_end     = (r_j == r_count);
        o_sts.div_busy  = div_busy;
        o_sts.converged = (n_dem == r_r);
    end

    assign o_out = r_out;

endmodule

>>> hw/rtl/gfrta_chk.sv
// port-level checker of the response time analysis block, with its bind
`include "global_fp_response_time_analysis_top_assert.svh"

module gfrta_chk
    import gfrta_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input t_out       o_out
);

    // a stalled result transaction stays offered
    `GFRTA_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid)

    // one task at a time: input is held off right after a transaction
    `GFRTA_ASSERT_NXT(a_one_at_a_time, i_valid && !o_stall, o_stall)

    // skipped tasks carry no response time
    `GFRTA_ASSERT_IMP(a_skip_zero,
        o_valid && (o_out.status == ST_NOTEXAM || o_out.status == ST_FULL),
        o_out.resp_time == 33'd0)

    // a miss clears the schedulable flag
    `GFRTA_ASSERT_IMP(a_miss_flag, o_valid && o_out.status == ST_MISS,
        !o_out.set_schedulable)

endmodule

bind global_fp_response_time_analysis_top gfrta_chk u_chk (.*);

>>> tb/global_fp_response_time_analysis_top_test.sv
// self-checking testbench for the global fixed-priority response time analysis block
`timescale 1ns / 1ps

module global_fp_response_time_analysis_top_test;
    import gfrta_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int ITER_CAP    = 40;
    localparam int RANDOM_TASKS = 560;

    typedef struct {
        int   cfg;
        t_in  task_in;
        bit   typed;
        t_out result;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in        i_in;
    logic       o_valid;
    logic       i_stall;
    t_out       o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;

    // analysis model state
    logic [6:0]  proc_cnt;
    logic [31:0] exec_tab [TABLE_DEPTH];
    logic [31:0] period_tab [TABLE_DEPTH];
    int          task_cnt;
    bit          miss_flag;

    t_out    result_q[$];
    t_row    directed[$];
    int      errors;
    longint  cycles;
    longint  cycle_limit;
    bit      quiet;
    int      stall_run;

    global_fp_response_time_analysis_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // fixed-point window iteration over the first tc stored tasks
    function automatic longint unsigned window_fixpoint(input longint unsigned wcet,
            input longint unsigned dl, input int tc, output int iters);
        longint unsigned procs;
        longint unsigned r;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned s;
        longint unsigned dem;
        longint unsigned c;
        longint unsigned p;
        longint unsigned n;
        procs = (proc_cnt == 0) ? 64'd1 : 64'(proc_cnt);
        r = wcet;
        iters = 0;
        while (r < dl) begin
            iters++;
            if (iters > ITER_CAP) return 0;
            sum = 0;
            for (int j = 0; j < tc; j++) begin
                c = 64'(exec_tab[j]);
                p = (period_tab[j] == 0) ? 64'd1 : 64'(period_tab[j]);
                n = r / p + ((r % p) != 0 ? 64'd1 : 64'd0);
                term = c * n + c;
                s = sum + term;
                sum = (s < sum) ? '1 : s;
            end
            s = sum / procs;
            dem = s + wcet;
            if (dem < s) dem = '1;
            if (dem == r) return r;
            r = dem;
        end
        return dl + 100;
    endfunction

    // report one field mismatch
    task automatic report(input string field, input longint unsigned exp_v,
            input longint unsigned act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        errors++;
    endtask

    // random prior bound within the 33-bit range of the field
    function automatic logic [32:0] rand_prior();
        if ($urandom_range(0, 3) == 0) return {1'b1, 32'($urandom_range(0, 100))};
        return {1'b0, 32'($urandom)};
    endfunction

    // predict, then send one task transaction
    task automatic send_task(input t_in x, input bit typed, input t_out texp);
        t_out            y;
        longint unsigned resp;
        int              iters;
        int              tc_used;
        int              gap;
        int              pick;
        if (x.first_of_set) begin
            task_cnt = 0;
            miss_flag = 0;
        end
        tc_used = task_cnt;
        iters = 0;
        y.task_index = 5'(task_cnt);
        y.resp_time = '0;
        y.new_bound = x.prior_bound;
        if (miss_flag) begin
            y.status = ST_NOTEXAM;
        end else if (task_cnt >= TABLE_DEPTH) begin
            y.status = ST_FULL;
        end else begin
            resp = window_fixpoint(64'(x.exec_time), 64'(x.task_deadline), task_cnt, iters);
            // keep the run short: a window that climbs too slowly becomes a plain miss
            if (iters > ITER_CAP) begin
                x.task_deadline = x.exec_time;
                resp = window_fixpoint(64'(x.exec_time), 64'(x.task_deadline), task_cnt, iters);
            end
            y.resp_time = 33'(resp);
            if (resp > 64'(x.task_deadline)) begin
                y.status = ST_MISS;
                miss_flag = 1;
            end else begin
                y.status = ST_FIT;
                if (33'(resp) > x.prior_bound) y.new_bound = 33'(resp);
            end
        end
        if (y.status != ST_FULL && task_cnt < TABLE_DEPTH) begin
            exec_tab[task_cnt] = x.exec_time;
            period_tab[task_cnt] = x.task_period;
            task_cnt++;
        end
        y.set_schedulable = !miss_flag;
        result_q.push_back(typed ? texp : y);
        cycle_limit += 4 * (longint'(iters) * (38 * tc_used + 69) + 4) + 400;

        // drive until accepted
        @(negedge i_clk);
        i_in <= x;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);

        // sender gap, mostly short
        pick = $urandom_range(0, 9);
        if (quiet || pick < 6) gap = 0;
        else if (pick < 9) gap = $urandom_range(1, 3);
        else gap = $urandom_range(15, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // processor count write, only once every result is back
    task automatic write_procs(input logic [6:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        proc_cnt = v;
    endtask

    task automatic add_row(input int cfg, input logic [31:0] e, input logic [31:0] p,
            input logic [31:0] d, input logic [32:0] pb, input logic f, input bit typed,
            input t_out res);
        t_row row;
        row.cfg = cfg;
        row.task_in = '{e, p, d, pb, f};
        row.typed = typed;
        row.result = res;
        directed.push_back(row);
    endtask

    // result stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    i_stall <= 1'b0;
                    stall_run <= $urandom_range(0, 6);
                end
                9: begin
                    i_stall <= !quiet;
                    stall_run <= $urandom_range(20, 40);
                end
                default: begin
                    i_stall <= !quiet;
                    stall_run <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, o_out);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (o_out.task_index !== e.task_index)
                    report("task_index", e.task_index, o_out.task_index);
                if (o_out.resp_time !== e.resp_time)
                    report("resp_time", e.resp_time, o_out.resp_time);
                if (o_out.new_bound !== e.new_bound)
                    report("new_bound", e.new_bound, o_out.new_bound);
                if (o_out.status !== e.status)
                    report("status", e.status, o_out.status);
                if (o_out.set_schedulable !== e.set_schedulable)
                    report("set_schedulable", e.set_schedulable, o_out.set_schedulable);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit) begin
            $display("FAIL global_fp_response_time_analysis_top");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_in x;
        int  sent;
        int  n;
        int  kind;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        cycle_limit = 200000;
        quiet = 0;
        stall_run = 0;
        proc_cnt = 7'd1;
        task_cnt = 0;
        miss_flag = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: misses, skipped tasks, zero period, extremes, processor counts
        add_row(-1, 5, 10, 3, 0, 1, 1, '{5'd0, 33'd103, 33'd0, ST_MISS, 1'b0});
        add_row(-1, 1, 1, 100, 7, 0, 1, '{5'd1, 33'd0, 33'd7, ST_NOTEXAM, 1'b0});
        add_row(-1, 0, 0, 0, 33'h100000063, 1, 1,
                '{5'd0, 33'd100, 33'h100000063, ST_MISS, 1'b0});
        add_row(-1, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1, 1,
                '{5'd0, 33'hFFFFFFFE, 33'hFFFFFFFE, ST_FIT, 1'b1});
        add_row(-1, 0, 0, 32'hFFFFFFFF, 33'h100000063, 0, 0, '{default: '0});
        add_row(-1, 10, 0, 1000, 0, 1, 1, '{5'd0, 33'd10, 33'd10, ST_FIT, 1'b1});
        add_row(-1, 10, 50, 1000, 500, 0, 0, '{default: '0});
        add_row(0, 3, 20, 400, 0, 1, 1, '{5'd0, 33'd3, 33'd3, ST_FIT, 1'b1});
        add_row(-1, 4, 30, 400, 0, 0, 0, '{default: '0});
        add_row(-1, 5, 40, 400, 0, 0, 0, '{default: '0});
        add_row(127, 7, 100, 100, 0, 1, 1, '{5'd0, 33'd7, 33'd7, ST_FIT, 1'b1});
        add_row(-1, 50, 200, 300, 0, 0, 0, '{default: '0});
        add_row(-1, 60, 300, 2000, 0, 0, 0, '{default: '0});
        add_row(64, 100, 1000, 1000, 33'h100000000, 1, 1,
                '{5'd0, 33'd100, 33'h100000000, ST_FIT, 1'b1});
        add_row(-1, 300, 700, 5000, 0, 0, 0, '{default: '0});
        add_row(1, 2, 5, 2, 9, 1, 1, '{5'd0, 33'd102, 33'd9, ST_MISS, 1'b0});
        add_row(-1, 0, 0, 0, 0, 0, 1, '{5'd1, 33'd0, 33'd0, ST_NOTEXAM, 1'b0});
        add_row(65, 1000, 5000, 5000, 0, 1, 1, '{5'd0, 33'd1000, 33'd1000, ST_FIT, 1'b1});
        add_row(-1, 2000, 8000, 8000, 0, 0, 0, '{default: '0});
        foreach (directed[i]) begin
            if (directed[i].cfg >= 0) write_procs(7'(directed[i].cfg));
            send_task(directed[i].task_in, directed[i].typed, directed[i].result);
        end

        // random task sets
        sent = 0;
        while (sent < RANDOM_TASKS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: write_procs(7'd0);
                    1: write_procs(7'd127);
                    2: write_procs(7'd1);
                    3: write_procs(7'd64);
                    4: write_procs(7'($urandom_range(2, 8)));
                    default: write_procs(7'($urandom_range(65, 126)));
                endcase
            end
            if ($urandom_range(0, 3) == 0) quiet = !quiet;
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                // zero-cost tasks that fill the table and overflow it
                for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
                    x = '{0, 32'($urandom), 32'($urandom) | 32'd1, rand_prior(), i == 0};
                    send_task(x, 0, '{default: '0});
                    sent++;
                end
            end else if (kind < 3) begin
                // unstructured noise
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    x = '{32'($urandom), 32'($urandom), 32'($urandom), rand_prior(),
                          1'($urandom_range(0, 1))};
                    send_task(x, 0, '{default: '0});
                    sent++;
                end
            end else begin
                // plausible task set with random content
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    x.task_period = ($urandom_range(0, 15) == 0) ? 32'd0 :
                                    32'($urandom_range(50, 4000));
                    x.exec_time = 32'($urandom_range(0, 32'(x.task_period) / 6 + 1));
                    x.task_deadline = x.exec_time + 32'($urandom_range(0, 4000));
                    x.prior_bound = ($urandom_range(0, 1) == 0) ? 33'($urandom_range(0, 3000))
                                                                  : rand_prior();
                    x.first_of_set = (i == 0);
                    send_task(x, 0, '{default: '0});
                    sent++;
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS global_fp_response_time_analysis_top");
        end else begin
            $display("FAIL global_fp_response_time_analysis_top");
        end
        $finish;
    end

endmodule
